FILE: src/i2cm_pkg.sv
package i2cm_pkg;

  localparam int unsigned CfgDataW = 8;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] CfgAckWaitLimit = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgPhaseTicks   = 1'd1;

  localparam logic [7:0] AckWaitReset    = 8'd50;
  localparam logic [7:0] PhaseTicksReset = 8'd1;
  localparam logic [7:0] MsbMask         = 8'h80;

  localparam logic [1:0] StatOk        = 2'd0;
  localparam logic [1:0] StatBusBusy   = 2'd1;
  localparam logic [1:0] StatAddrNack  = 2'd2;
  localparam logic [1:0] StatDataNack  = 2'd3;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_DATA  = 2'd3
  } mode_e;

  typedef enum logic [4:0] {
    S_IDLE       = 5'd0,
    S_RS_LOW     = 5'd1,
    S_START_REL  = 5'd2,
    S_START_LOW  = 5'd3,
    S_START_END  = 5'd4,
    S_BIT_LOW    = 5'd5,
    S_BIT_HIGH   = 5'd6,
    S_ACK_LOW    = 5'd7,
    S_ACK_HIGH   = 5'd8,
    S_ACK_WAIT   = 5'd9,
    S_WAIT_DATA  = 5'd10,
    S_RD_LOW     = 5'd11,
    S_RD_HIGH    = 5'd12,
    S_MACK_LOW   = 5'd13,
    S_MACK_HIGH  = 5'd14,
    S_STOP_LOW   = 5'd15,
    S_STOP_RISE  = 5'd16,
    S_STOP_REL   = 5'd17
  } seq_e;

  typedef enum logic [1:0] {
    STG_ADDR_W = 2'd0,
    STG_REG    = 2'd1,
    STG_DATA   = 2'd2,
    STG_ADDR_R = 2'd3
  } stage_e;

  typedef struct packed {
    logic [7:0] ack_wait_limit;
    logic [7:0] phase_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] data_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    seq_e       seq;
    logic [7:0] shift_byte;
    logic [3:0] bit_cnt;
    logic [7:0] bytes_left;
    logic [7:0] phase_cnt;
    logic [7:0] ack_cnt;
    logic       is_read;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic       pend_vld;
    logic [7:0] pend_byte;
    stage_e     stage;
    logic [1:0] res_status;
  } st_t;

  typedef struct packed {
    logic       scl;
    logic       sda_drive_low;
    logic       data_request;
    logic       read_valid;
    logic [7:0] read_data;
    logic       read_last;
    logic       done_res;
    logic [1:0] status;
    logic       busy_res;
  } res_t;

endpackage

FILE: src/i2cm_in_if.sv
interface i2cm_in_if;
  import i2cm_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [6:0] dev_addr;
  logic [7:0] reg_addr;
  logic [7:0] byte_count;
  logic [7:0] data_byte;
  logic       sda_in;

  modport source (
    output valid, mode, dev_addr, reg_addr, byte_count, data_byte, sda_in,
    input  ready
  );

  modport sink (
    input  valid, mode, dev_addr, reg_addr, byte_count, data_byte, sda_in,
    output ready
  );

endinterface

FILE: src/i2cm_out_if.sv
interface i2cm_out_if;
  import i2cm_pkg::*;

  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_drive_low;
  logic       data_request;
  logic       read_valid;
  logic [7:0] read_data;
  logic       read_last;
  logic       done_res;
  logic [1:0] status;
  logic       busy_res;

  modport source (
    output valid, scl, sda_drive_low, data_request, read_valid, read_data,
           read_last, done_res, status, busy_res,
    input  ready
  );

  modport sink (
    input  valid, scl, sda_drive_low, data_request, read_valid, read_data,
           read_last, done_res, status, busy_res,
    output ready
  );

endinterface

FILE: src/i2cm_step.sv
module i2cm_step (
  input  i2cm_pkg::st_t   st_i,
  input  i2cm_pkg::item_t item_i,
  input  i2cm_pkg::cfg_t  cfg_i,
  output i2cm_pkg::st_t   st_o,
  output i2cm_pkg::res_t  res_o
);
  import i2cm_pkg::*;

  function automatic st_t f_load(st_t s, logic [7:0] b);
    st_t r;
    r = s;
    r.shift_byte = b;
    r.bit_cnt    = '0;
    r.seq        = S_BIT_LOW;
    return r;
  endfunction

  function automatic st_t f_stop(st_t s, logic [1:0] code);
    st_t r;
    r = s;
    r.res_status = code;
    r.seq        = S_STOP_LOW;
    return r;
  endfunction

  function automatic st_t f_next_data(st_t s);
    st_t r;
    r = s;
    if (s.bytes_left == 8'd0) begin
      r = f_stop(s, StatOk);
    end else if (s.pend_vld) begin
      r.pend_vld = 1'b0;
      r.stage    = STG_DATA;
      r = f_load(r, s.pend_byte);
    end else begin
      r.stage = STG_DATA;
      r.seq   = S_WAIT_DATA;
    end
    return r;
  endfunction

  function automatic st_t f_ack_result(st_t s, logic acked);
    st_t r;
    r = s;
    case (s.stage)
      STG_ADDR_W: begin
        if (!acked) begin
          r = f_stop(s, StatAddrNack);
        end else begin
          r.stage = STG_REG;
          r = f_load(r, s.reg_addr);
        end
      end
      STG_REG: begin
        if (s.is_read) begin
          r.stage = STG_ADDR_R;
          r.seq   = S_RS_LOW;
        end else begin
          r = f_next_data(s);
        end
      end
      STG_DATA: begin
        if (!acked) begin
          r = f_stop(s, StatDataNack);
        end else begin
          r.bytes_left = s.bytes_left - 8'd1;
          r = f_next_data(r);
        end
      end
      default: begin
        if (s.bytes_left == 8'd0) begin
          r = f_stop(s, StatOk);
        end else begin
          r.shift_byte = '0;
          r.bit_cnt    = '0;
          r.seq        = S_RD_LOW;
        end
      end
    endcase
    return r;
  endfunction

  function automatic st_t f_ack_check(st_t s, logic sda, logic [7:0] limit);
    st_t r;
    r = s;
    if (!sda) begin
      r = f_ack_result(s, 1'b1);
    end else if (s.ack_cnt >= limit) begin
      r = f_ack_result(s, 1'b0);
    end else begin
      r.ack_cnt = s.ack_cnt + 8'd1;
      r.seq     = S_ACK_WAIT;
    end
    return r;
  endfunction

  st_t        s;
  logic [7:0] limit;
  logic [8:0] phase_p1;
  logic [3:0] bit_p1;
  logic [7:0] rd_byte;
  logic       bitlow;
  logic       mack_drive;
  logic       rd_vld;
  logic       done;
  logic [1:0] done_code;

  always_comb begin
    s         = st_i;
    rd_vld    = 1'b0;
    rd_byte   = s.shift_byte;
    done      = 1'b0;
    done_code = StatOk;
    limit     = (cfg_i.phase_ticks == 8'd0) ? 8'd1 : cfg_i.phase_ticks;
    phase_p1  = {1'b0, st_i.phase_cnt} + 9'd1;
    bit_p1    = st_i.bit_cnt + 4'd1;

    case (mode_e'(item_i.mode))
      MODE_WRITE, MODE_READ: begin
        if (st_i.seq == S_IDLE) begin
          s.dev_addr   = item_i.dev_addr;
          s.reg_addr   = item_i.reg_addr;
          s.bytes_left = item_i.byte_count;
          s.is_read    = (mode_e'(item_i.mode) == MODE_READ);
          s.pend_vld   = 1'b0;
          s.stage      = STG_ADDR_W;
          s.res_status = StatOk;
          s.phase_cnt  = '0;
          s.ack_cnt    = '0;
          s.seq        = S_START_REL;
        end
      end
      MODE_DATA: begin
        if (st_i.seq != S_IDLE && !st_i.is_read) begin
          if (st_i.seq == S_WAIT_DATA) begin
            s.pend_vld  = 1'b0;
            s.phase_cnt = '0;
            s = f_load(s, item_i.data_byte);
          end else begin
            s.pend_byte = item_i.data_byte;
            s.pend_vld  = 1'b1;
          end
        end
      end
      default: begin
        if (st_i.seq == S_ACK_WAIT) begin
          s.phase_cnt = '0;
          s = f_ack_check(s, item_i.sda_in, cfg_i.ack_wait_limit);
        end else if (st_i.seq != S_IDLE) begin
          if (phase_p1 >= {1'b0, limit}) begin
            s.phase_cnt = '0;
            unique case (st_i.seq)
              S_RS_LOW:    s.seq = S_START_REL;
              S_START_REL: begin
                if (!item_i.sda_in) begin
                  s.seq     = S_IDLE;
                  done      = 1'b1;
                  done_code = StatBusBusy;
                end else begin
                  s.seq = S_START_LOW;
                end
              end
              S_START_LOW: begin
                if (item_i.sda_in) begin
                  s.seq     = S_IDLE;
                  done      = 1'b1;
                  done_code = StatBusBusy;
                end else begin
                  s.seq = S_START_END;
                end
              end
              S_START_END: begin
                s = f_load(s, {st_i.dev_addr, (st_i.stage == STG_ADDR_R)});
              end
              S_BIT_LOW:   s.seq = S_BIT_HIGH;
              S_BIT_HIGH: begin
                s.shift_byte = {st_i.shift_byte[6:0], 1'b0};
                s.bit_cnt    = bit_p1;
                if (bit_p1 >= 4'd8) begin
                  s.ack_cnt = '0;
                  s.seq     = S_ACK_LOW;
                end else begin
                  s.seq = S_BIT_LOW;
                end
              end
              S_ACK_LOW:   s.seq = S_ACK_HIGH;
              S_ACK_HIGH: begin
                s = f_ack_check(s, item_i.sda_in, cfg_i.ack_wait_limit);
              end
              S_RD_LOW:    s.seq = S_RD_HIGH;
              S_RD_HIGH: begin
                s.shift_byte = {st_i.shift_byte[6:0], item_i.sda_in};
                s.bit_cnt    = bit_p1;
                if (bit_p1 >= 4'd8) begin
                  rd_vld  = 1'b1;
                  rd_byte = s.shift_byte;
                  s.seq   = S_MACK_LOW;
                end else begin
                  s.seq = S_RD_LOW;
                end
              end
              S_MACK_LOW:  s.seq = S_MACK_HIGH;
              S_MACK_HIGH: begin
                s.bytes_left = st_i.bytes_left - 8'd1;
                if (s.bytes_left == 8'd0) begin
                  s = f_stop(s, StatOk);
                end else begin
                  s.shift_byte = '0;
                  s.bit_cnt    = '0;
                  s.seq        = S_RD_LOW;
                end
              end
              S_STOP_LOW:  s.seq = S_STOP_RISE;
              S_STOP_RISE: s.seq = S_STOP_REL;
              S_STOP_REL: begin
                s.seq     = S_IDLE;
                done      = 1'b1;
                done_code = st_i.res_status;
              end
              S_WAIT_DATA: s.seq = S_WAIT_DATA;
              default:     s.seq = S_IDLE;
            endcase
          end else begin
            s.phase_cnt = phase_p1[7:0];
          end
        end
      end
    endcase
  end

  assign st_o = s;

  always_comb begin
    bitlow     = ((s.shift_byte & MsbMask) == 8'd0);
    mack_drive = (s.bytes_left > 8'd1);
    res_o      = '0;
    res_o.scl           = 1'b1;
    res_o.sda_drive_low = 1'b0;
    unique case (s.seq)
      S_RS_LOW: begin
        res_o.scl = 1'b0;
      end
      S_START_LOW: begin
        res_o.sda_drive_low = 1'b1;
      end
      S_START_END, S_STOP_LOW: begin
        res_o.scl           = 1'b0;
        res_o.sda_drive_low = 1'b1;
      end
      S_BIT_LOW: begin
        res_o.scl           = 1'b0;
        res_o.sda_drive_low = bitlow;
      end
      S_BIT_HIGH: begin
        res_o.sda_drive_low = bitlow;
      end
      S_ACK_LOW, S_WAIT_DATA, S_RD_LOW: begin
        res_o.scl = 1'b0;
      end
      S_MACK_LOW: begin
        res_o.scl           = 1'b0;
        res_o.sda_drive_low = mack_drive;
      end
      S_MACK_HIGH: begin
        res_o.sda_drive_low = mack_drive;
      end
      S_STOP_RISE: begin
        res_o.sda_drive_low = 1'b1;
      end
      default: begin
        res_o.scl = 1'b1;
      end
    endcase
    res_o.data_request = (s.seq == S_WAIT_DATA);
    res_o.read_valid   = rd_vld;
    res_o.read_data    = rd_vld ? rd_byte : 8'd0;
    res_o.read_last    = rd_vld && (st_i.bytes_left == 8'd1);
    res_o.done_res     = done;
    res_o.status       = done ? done_code : StatOk;
    res_o.busy_res     = (s.seq != S_IDLE);
  end

endmodule

FILE: src/i2c_master_register_access_top.sv
// Channel | Direction | Payload
// in_s    | sink      | mode, dev_addr, reg_addr, byte_count, data_byte, sda_in
// out_s   | source    | scl, sda_drive_low, data_request, read_*, done_res, status, busy_res
// cfg     | write     | cfg_we_i, cfg_idx_i, cfg_data_i
//
// Each accepted item updates the sequencer state and loads its result into the
// output register in the same cycle, so one item is taken per clock unless out_s stalls.
// The result is registered in the output register when the item is accepted.
// A new item is taken whenever the output register is empty or being emptied.
// Reset idles the sequencer, clears the output valid and restores the config defaults.
module i2c_master_register_access_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  i2cm_in_if.sink                       in_s,
  i2cm_out_if.source                    out_s,
  input  logic                          cfg_we_i,
  input  logic [i2cm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [i2cm_pkg::CfgDataW-1:0] cfg_data_i
);
  import i2cm_pkg::*;

  cfg_t  cfg_q;
  st_t   st_q;
  st_t   st_d;
  item_t item;
  res_t  res_d;
  res_t  res_q;
  logic  out_vld_q;
  logic  in_rdy;
  logic  in_acc;

  assign in_rdy = !out_vld_q || out_s.ready;
  assign in_acc = in_s.valid && in_rdy;
  assign in_s.ready = in_rdy;

  assign item.mode       = in_s.mode;
  assign item.dev_addr   = in_s.dev_addr;
  assign item.reg_addr   = in_s.reg_addr;
  assign item.byte_count = in_s.byte_count;
  assign item.data_byte  = in_s.data_byte;
  assign item.sda_in     = in_s.sda_in;

  i2cm_step u_step (
    .st_i   (st_q),
    .item_i (item),
    .cfg_i  (cfg_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ack_wait_limit <= AckWaitReset;
      cfg_q.phase_ticks    <= PhaseTicksReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgAckWaitLimit: cfg_q.ack_wait_limit <= cfg_data_i;
        CfgPhaseTicks:   cfg_q.phase_ticks    <= cfg_data_i;
        default:         cfg_q                <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        st_q <= st_d;
      end
      if (in_rdy) begin
        out_vld_q <= in_s.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_s.valid         = out_vld_q;
  assign out_s.scl           = res_q.scl;
  assign out_s.sda_drive_low = res_q.sda_drive_low;
  assign out_s.data_request  = res_q.data_request;
  assign out_s.read_valid    = res_q.read_valid;
  assign out_s.read_data     = res_q.read_data;
  assign out_s.read_last     = res_q.read_last;
  assign out_s.done_res      = res_q.done_res;
  assign out_s.status        = res_q.status;
  assign out_s.busy_res      = res_q.busy_res;

endmodule
